// ===== rtl/otpm_pkg.sv =====
// otpm_pkg: shared types and constants of the orientation to pointer mapper
// used by every rtl file of the block, depends on nothing

package otpm_pkg;

  localparam int QUAT_W = 16;
  localparam int R_W    = 34;   // rotation matrix entries scaled by 2^30, doubled
  localparam int MAG_W  = 33;   // magnitude of an R_W value
  localparam int DIV_W  = 57;   // divider working width: MAG_W + 24
  localparam int Q_W    = 24;   // projection quotient, Q8 mm
  localparam int S_W    = 24;   // smoothed value, Q8 mm
  localparam int Q_STEPS = 24;  // quotient bits produced by the divider
  localparam int CNT_W  = 5;
  localparam int PROD_W = 42;   // smoothing products
  localparam int PIX_W  = 26;   // pixel sum before saturation

  localparam logic [Q_W-1:0] PROJ_LIM = 24'd8388352;  // 32767 * 256

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PPM_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PPM_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd4;

  localparam logic [14:0] CENTER_X_RST = 15'd960;
  localparam logic [14:0] CENTER_Y_RST = 15'd540;
  localparam logic [7:0]  PPM_X_RST    = 8'd3;
  localparam logic [7:0]  PPM_Y_RST    = 8'd3;
  localparam logic [15:0] GAIN_RST     = 16'd5461;

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
    logic               projection_saturated;
  } out_item_t;

  typedef struct packed {
    logic [14:0] center_x;
    logic [14:0] center_y;
    logic [7:0]  pixels_per_mm_x;
    logic [7:0]  pixels_per_mm_y;
    logic [15:0] smoothing_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [R_W-1:0] r01;
    logic signed [R_W-1:0] r11;
    logic signed [R_W-1:0] nr21;   // -r21, numerator of the vertical axis
    logic                  den_zero;
  } qentry_t;

endpackage

// ===== rtl/otpm_front.sv =====
// otpm_front: accepts quaternions, forms r01, r11, -r21 and flags a zero r11
// depends on otpm_pkg

module otpm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  otpm_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               push,
  output otpm_pkg::qentry_t  push_data
);

  logic               v1;
  logic signed [31:0] p_xy, p_wz, p_xx, p_zz, p_yz, p_wx;
  logic signed [otpm_pkg::R_W-1:0] d01, s11, s21;

  assign push     = v1 && !q_full;
  assign in_ready = !v1 || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_xy <= in_data.quat_x * in_data.quat_y;
      p_wz <= in_data.quat_w * in_data.quat_z;
      p_xx <= in_data.quat_x * in_data.quat_x;
      p_zz <= in_data.quat_z * in_data.quat_z;
      p_yz <= in_data.quat_y * in_data.quat_z;
      p_wx <= in_data.quat_w * in_data.quat_x;
    end
  end

  always_comb begin
    d01 = 34'(p_xy) - 34'(p_wz);
    s11 = 34'(p_xx) + 34'(p_zz);
    s21 = 34'(p_yz) + 34'(p_wx);
    push_data.r01      = {d01[32:0], 1'b0};
    push_data.r11      = 34'sh40000000 - {s11[32:0], 1'b0};
    push_data.nr21     = 34'sd0 - {s21[32:0], 1'b0};
    push_data.den_zero = (push_data.r11 == 34'sd0);
  end

endmodule

// ===== rtl/otpm_queue.sv =====
// otpm_queue: two-entry queue between front and back
// depends on otpm_pkg

module otpm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  otpm_pkg::qentry_t push_data,
  output logic              full,
  input  logic              pop,
  output otpm_pkg::qentry_t pop_data,
  output logic              empty
);

  otpm_pkg::qentry_t                 mem [otpm_pkg::QDEPTH];
  logic [otpm_pkg::QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [otpm_pkg::QCNT_W-1:0]       count;

  assign full     = (count == otpm_pkg::QCNT_W'(otpm_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/otpm_back.sv =====
// otpm_back: projection divider, exponential smoothing and pixel mapping
// depends on otpm_pkg

module otpm_back (
  input  logic                clk,
  input  logic                rst,
  input  otpm_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  otpm_pkg::qentry_t   q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output otpm_pkg::out_item_t out_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCALE = 9'b000000010,
    S_RANGE = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_CLAMP = 9'b000010000,
    S_SMUL  = 9'b000100000,
    S_SACC  = 9'b001000000,
    S_PMUL  = 9'b010000000,
    S_PIX   = 9'b100000000
  } state_t;

  state_t state;

  logic [otpm_pkg::MAG_W-1:0] m0, m1, md;
  logic                       sgn0, sgn1, dneg, dz, nz0, nz1;
  logic [otpm_pkg::DIV_W-1:0] rem0, rem1, dsh;
  logic [otpm_pkg::Q_W-1:0]   q0, q1;
  logic                       ovf0, ovf1;
  logic [otpm_pkg::CNT_W-1:0] cnt;
  logic signed [otpm_pkg::Q_W-1:0]    p0, p1;
  logic                               sat_r;
  logic signed [otpm_pkg::PROD_W-1:0] ma0, mb0, ma1, mb1;
  logic signed [otpm_pkg::S_W-1:0]    sx, sy;
  logic [31:0]                        pm0, pm1;
  logic                               sgx, sgy;

  logic [otpm_pkg::R_W-1:0]   n01, n21, n11;
  logic                       ge0, ge1, big0, big1, pix_go;
  logic [otpm_pkg::Q_W-1:0]   qm0, qm1;
  logic signed [otpm_pkg::Q_W-1:0]    pn0, pn1;
  logic [16:0]                        ga;
  logic signed [otpm_pkg::PROD_W-1:0] sum0, sum1;
  logic [otpm_pkg::S_W-1:0]           msx, msy;
  logic signed [otpm_pkg::PIX_W-1:0]  tx, ty, vx, vy;
  logic signed [15:0]                 ox, oy;

  assign pop    = (state == S_IDLE) && !q_empty;
  assign pix_go = (state == S_PIX) && (!out_valid || out_ready);

  always_comb begin
    n01 = 34'd0 - q_data.r01;
    n21 = 34'd0 - q_data.nr21;
    n11 = 34'd0 - q_data.r11;

    ge0 = rem0 >= dsh;
    ge1 = rem1 >= dsh;

    // zero divisor gives the limit with the numerator's sign, or zero
    big0 = ovf0 || (q0 > otpm_pkg::PROJ_LIM);
    big1 = ovf1 || (q1 > otpm_pkg::PROJ_LIM);
    if (dz) begin
      qm0 = nz0 ? otpm_pkg::PROJ_LIM : '0;
      qm1 = nz1 ? otpm_pkg::PROJ_LIM : '0;
    end else begin
      qm0 = big0 ? otpm_pkg::PROJ_LIM : q0;
      qm1 = big1 ? otpm_pkg::PROJ_LIM : q1;
    end
    pn0 = (sgn0 ^ dneg) ? $signed(24'd0 - qm0) : $signed(qm0);
    pn1 = (sgn1 ^ dneg) ? $signed(24'd0 - qm1) : $signed(qm1);

    ga   = 17'h10000 - {1'b0, cfg.smoothing_gain};
    sum0 = ma0 + mb0;
    sum1 = ma1 + mb1;

    msx = sx[otpm_pkg::S_W-1] ? 24'd0 - sx : sx;
    msy = sy[otpm_pkg::S_W-1] ? 24'd0 - sy : sy;

    tx = $signed({2'b00, pm0[31:8]});
    ty = $signed({2'b00, pm1[31:8]});
    vx = (sgx ? -tx : tx) + $signed({11'd0, cfg.center_x});
    vy = (sgy ? -ty : ty) + $signed({11'd0, cfg.center_y});
    if (vx > 26'sd32767) begin
      ox = 16'sd32767;
    end else if (vx < -26'sd32768) begin
      ox = -16'sd32768;
    end else begin
      ox = vx[15:0];
    end
    if (vy > 26'sd32767) begin
      oy = 16'sd32767;
    end else if (vy < -26'sd32768) begin
      oy = -16'sd32768;
    end else begin
      oy = vy[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sx        <= '0;
      sy        <= '0;
    end else begin
      if (pix_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            m0    <= q_data.r01[33] ? n01[32:0] : q_data.r01[32:0];
            m1    <= q_data.nr21[33] ? n21[32:0] : q_data.nr21[32:0];
            md    <= q_data.r11[33] ? n11[32:0] : q_data.r11[32:0];
            sgn0  <= q_data.r01[33];
            sgn1  <= q_data.nr21[33];
            dneg  <= q_data.r11[33];
            dz    <= q_data.den_zero;
            nz0   <= (q_data.r01 != '0);
            nz1   <= (q_data.nr21 != '0);
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          // 256000 = 2^18 - 2^12 - 2^11
          rem0  <= (57'(m0) << 18) - (57'(m0) << 12) - (57'(m0) << 11);
          rem1  <= (57'(m1) << 18) - (57'(m1) << 12) - (57'(m1) << 11);
          dsh   <= 57'(md) << (otpm_pkg::Q_STEPS - 1);
          state <= S_RANGE;
        end
        S_RANGE: begin
          // quotient of 2^24 or more is out of range anyway
          ovf0  <= rem0 >= {dsh[otpm_pkg::DIV_W-2:0], 1'b0};
          ovf1  <= rem1 >= {dsh[otpm_pkg::DIV_W-2:0], 1'b0};
          q0    <= '0;
          q1    <= '0;
          cnt   <= otpm_pkg::CNT_W'(otpm_pkg::Q_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (ge0) rem0 <= rem0 - dsh;
          if (ge1) rem1 <= rem1 - dsh;
          q0  <= {q0[otpm_pkg::Q_W-2:0], ge0};
          q1  <= {q1[otpm_pkg::Q_W-2:0], ge1};
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_CLAMP;
        end
        S_CLAMP: begin
          p0    <= pn0;
          p1    <= pn1;
          sat_r <= dz || big0 || big1;
          state <= S_SMUL;
        end
        S_SMUL: begin
          ma0   <= $signed({1'b0, ga}) * sx;
          mb0   <= $signed({1'b0, cfg.smoothing_gain}) * p0;
          ma1   <= $signed({1'b0, ga}) * sy;
          mb1   <= $signed({1'b0, cfg.smoothing_gain}) * p1;
          state <= S_SACC;
        end
        S_SACC: begin
          // arithmetic shift by 16 rounds toward minus infinity
          sx    <= sum0[39:16];
          sy    <= sum1[39:16];
          state <= S_PMUL;
        end
        S_PMUL: begin
          pm0   <= msx * cfg.pixels_per_mm_x;
          pm1   <= msy * cfg.pixels_per_mm_y;
          sgx   <= sx[otpm_pkg::S_W-1];
          sgy   <= sy[otpm_pkg::S_W-1];
          state <= S_PIX;
        end
        S_PIX: begin
          if (pix_go) begin
            out_data.pointer_x            <= ox;
            out_data.pointer_y            <= oy;
            out_data.projection_saturated <= sat_r;
            state                         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/orientation_to_pointer_mapper_top.sv =====
// the back unit takes one beat at a time, paced by its 24-step shared quotient loop,
//   which works on both axes at once
// the front and a two-entry queue take up to three more beats while the back is busy
// synchronous active-high reset: registers return to their reset values,
//   smoothed positions clear to zero, queue and output register empty
// holds the register file and joins front, queue and back; uses otpm_pkg

module orientation_to_pointer_mapper_top (
  input  logic                                clk,
  input  logic                                rst,
  // input beats: one quaternion each
  input  logic                                in_valid,
  output logic                                in_ready,
  input  otpm_pkg::in_item_t                  in_data,
  // output beats: one pointer position each
  output logic                                out_valid,
  input  logic                                out_ready,
  output otpm_pkg::out_item_t                 out_data,
  // register writes
  input  logic                                cfg_wr_en,
  input  logic [otpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [otpm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  otpm_pkg::cfg_t    cfg;
  otpm_pkg::qentry_t push_data, pop_data;
  logic              push, pop, q_full, q_empty;

  // register file; unknown indexes are dropped, wide data is truncated
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x        <= otpm_pkg::CENTER_X_RST;
      cfg.center_y        <= otpm_pkg::CENTER_Y_RST;
      cfg.pixels_per_mm_x <= otpm_pkg::PPM_X_RST;
      cfg.pixels_per_mm_y <= otpm_pkg::PPM_Y_RST;
      cfg.smoothing_gain  <= otpm_pkg::GAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        otpm_pkg::CFG_CENTER_X: cfg.center_x        <= cfg_data[14:0];
        otpm_pkg::CFG_CENTER_Y: cfg.center_y        <= cfg_data[14:0];
        otpm_pkg::CFG_PPM_X:    cfg.pixels_per_mm_x <= cfg_data[7:0];
        otpm_pkg::CFG_PPM_Y:    cfg.pixels_per_mm_y <= cfg_data[7:0];
        otpm_pkg::CFG_GAIN:     cfg.smoothing_gain  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: quaternion products, then rotation matrix entries
  otpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decouples the front from the long back-end sequence
  otpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // back: divide, clamp, smooth, scale to pixels, output register
  otpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
